>>> rtl/qrrs_pkg.sv
// package for the quantum round robin scheduler
// holds widths, item kinds and thread states; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qrrs_pkg;
    localparam int unsigned THREAD_COUNT_DEF = 32;
    localparam logic [31:0] QUANTUM_RESET = 32'd50000;
    localparam int unsigned TID_W = 5;

    typedef enum logic [1:0] {
        KIND_SCHED   = 2'd0,
        KIND_READY   = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;
    localparam logic [1:0] ST_ZOMBIE  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  thread_id;
        logic [63:0] now;
        logic [1:0]  current_state;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  next_thread;
        logic        next_is_idle;
        logic [63:0] outgoing_cpu_time;
        logic        quantum_exhausted;
        logic        queue_error;
    } out_item_t;
endpackage
`default_nettype wire

>>> rtl/qrrs_if.sv
// valid/ready channel interface carrying one scheduler transaction payload
// depends on qrrs_pkg
`timescale 1ns / 1ps
`default_nettype none
interface qrrs_in_if;
    logic valid;
    logic ready;
    qrrs_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qrrs_out_if;
    logic valid;
    logic ready;
    qrrs_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/quantum_round_robin_scheduler_core.sv
// Make items go S_READ, S_OUT; schedule items go S_READ, S_CHARGE, S_QUANT (for a
// thread outgoing; S_CHARGE alone if idle, neither if none), S_PICK, S_POP, S_OUT;
// the next transaction is accepted in the cycle after the result is taken; the
// shared 64-bit adder/subtractor and the thread tables set the sequence length.
// Reset: asynchronous, queues empty, no current thread, quantum 50000;
// quantum and cpu tables use valid bits (unwritten entries read as 50000 and zero).
`timescale 1ns / 1ps
`default_nettype none
module quantum_round_robin_scheduler_core #(
    parameter int unsigned THREAD_COUNT = qrrs_pkg::THREAD_COUNT_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    qrrs_in_if.sink     in_ch,
    qrrs_out_if.source  out_ch,
    input  wire         cfg_we,
    input  wire [31:0]  cfg_wdata
);
    localparam int unsigned IW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int unsigned CW = $clog2(THREAD_COUNT + 1);
    localparam int unsigned TW = $clog2(THREAD_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHARGE, S_QUANT, S_PICK, S_POP, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] qlen_reg;
    qrrs_pkg::in_item_t item_reg;
    qrrs_pkg::out_item_t res_reg;

    // queue slot memories and pointers
    logic [qrrs_pkg::TID_W-1:0] slots_a [THREAD_COUNT];
    logic [qrrs_pkg::TID_W-1:0] slots_b [THREAD_COUNT];
    logic [IW-1:0] head_reg [2];
    logic [IW-1:0] tail_reg [2];
    logic [CW-1:0] cnt_reg [2];
    logic ready_is_b_reg;

    // thread tables
    logic [31:0] quant_mem [THREAD_COUNT];
    logic [THREAD_COUNT-1:0] qv_reg;
    logic [63:0] cpu_mem [THREAD_COUNT+1];
    logic [THREAD_COUNT:0] cv_reg;
    logic [31:0] quant_rd_reg;
    logic [63:0] cpu_rd_reg;

    logic cur_valid_reg, cur_idle_reg;
    logic [IW-1:0] cur_id_reg;
    logic [63:0] start_reg;
    logic [63:0] runtime_reg;
    logic [63:0] alu_a, alu_b, alu_sum;
    logic alu_sub;
    logic [TW-1:0] idx;
    logic tid_ok;
    logic [qrrs_pkg::TID_W-1:0] pop_rd;

    assign idx = cur_idle_reg ? TW'(THREAD_COUNT) : TW'(cur_id_reg);
    assign tid_ok = (32'(item_reg.thread_id) < THREAD_COUNT);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data = res_reg;

    // shared 64-bit adder/subtractor
    always_comb
    begin
        alu_a = 64'd0;
        alu_b = 64'd0;
        alu_sub = 1'b0;
        case (state_reg)
            S_READ:
            begin
                alu_a = item_reg.now;
                alu_b = start_reg;
                alu_sub = 1'b1;
            end
            S_CHARGE:
            begin
                alu_a = cpu_rd_reg;
                alu_b = runtime_reg;
            end
            S_QUANT:
            begin
                alu_a = {32'd0, quant_rd_reg};
                alu_b = runtime_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = 64'd0;
            end
        endcase
        alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    assign pop_rd = ready_is_b_reg ? slots_b[head_reg[1]] : slots_a[head_reg[0]];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic q;
        logic full;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            qlen_reg <= qrrs_pkg::QUANTUM_RESET;
            head_reg[0] <= '0; head_reg[1] <= '0;
            tail_reg[0] <= '0; tail_reg[1] <= '0;
            cnt_reg[0] <= '0; cnt_reg[1] <= '0;
            ready_is_b_reg <= 1'b0;
            qv_reg <= '0;
            cv_reg <= '0;
            cur_valid_reg <= 1'b0;
            cur_idle_reg <= 1'b0;
            cur_id_reg <= '0;
            start_reg <= '0;
        end
        else
        begin
            q = 1'b0;
            full = 1'b0;
            if (cfg_we)
                qlen_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        item_reg <= in_ch.data;
                        res_reg <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    runtime_reg <= alu_sum;
                    cpu_rd_reg <= cv_reg[idx] ? cpu_mem[idx] : 64'd0;
                    quant_rd_reg <= qv_reg[cur_id_reg] ? quant_mem[cur_id_reg]
                                    : qrrs_pkg::QUANTUM_RESET;
                    state_reg <= S_OUT;
                    if (item_reg.kind == qrrs_pkg::KIND_READY ||
                        item_reg.kind == qrrs_pkg::KIND_EXPIRED)
                    begin
                        if (tid_ok)
                        begin
                            q = (item_reg.kind == qrrs_pkg::KIND_EXPIRED) ^ ready_is_b_reg;
                            if (item_reg.kind == qrrs_pkg::KIND_EXPIRED)
                            begin
                                quant_mem[IW'(item_reg.thread_id)] <= qlen_reg;
                                qv_reg[IW'(item_reg.thread_id)] <= 1'b1;
                            end
                            full = (32'(cnt_reg[q]) >= THREAD_COUNT);
                            res_reg.queue_error <= full;
                            if (!full)
                            begin
                                if (q) slots_b[tail_reg[1]] <= item_reg.thread_id;
                                else slots_a[tail_reg[0]] <= item_reg.thread_id;
                                tail_reg[q] <= (32'(tail_reg[q]) + 1 >= THREAD_COUNT) ? '0
                                               : tail_reg[q] + 1'b1;
                                cnt_reg[q] <= cnt_reg[q] + 1'b1;
                            end
                        end
                    end
                    else if (item_reg.kind == qrrs_pkg::KIND_SCHED)
                        state_reg <= cur_valid_reg ? S_CHARGE : S_PICK;
                end
                S_CHARGE:
                begin
                    cpu_mem[idx] <= alu_sum;
                    cv_reg[idx] <= 1'b1;
                    res_reg.outgoing_cpu_time <= alu_sum;
                    state_reg <= cur_idle_reg ? S_PICK : S_QUANT;
                end
                S_QUANT:
                begin
                    state_reg <= S_PICK;
                    if (item_reg.current_state == qrrs_pkg::ST_RUNNING)
                    begin
                        qv_reg[cur_id_reg] <= 1'b1;
                        if (runtime_reg >= {32'd0, quant_rd_reg})
                        begin
                            quant_mem[cur_id_reg] <= qlen_reg;
                            q = ~ready_is_b_reg;
                        end
                        else
                        begin
                            quant_mem[cur_id_reg] <= alu_sum[31:0];
                            q = ready_is_b_reg;
                        end
                        full = (32'(cnt_reg[q]) >= THREAD_COUNT);
                        res_reg.queue_error <= full;
                        if (!full)
                        begin
                            if (q) slots_b[tail_reg[1]] <= qrrs_pkg::TID_W'(cur_id_reg);
                            else slots_a[tail_reg[0]] <= qrrs_pkg::TID_W'(cur_id_reg);
                            tail_reg[q] <= (32'(tail_reg[q]) + 1 >= THREAD_COUNT) ? '0
                                           : tail_reg[q] + 1'b1;
                            cnt_reg[q] <= cnt_reg[q] + 1'b1;
                        end
                    end
                    else if (item_reg.current_state == qrrs_pkg::ST_WAITING)
                    begin
                        qv_reg[cur_id_reg] <= 1'b1;
                        if (runtime_reg >= {32'd0, quant_rd_reg})
                        begin
                            quant_mem[cur_id_reg] <= 32'd0;
                            res_reg.quantum_exhausted <= 1'b1;
                        end
                        else
                            quant_mem[cur_id_reg] <= alu_sum[31:0];
                    end
                end
                S_PICK:
                begin
                    if (cnt_reg[ready_is_b_reg] == '0)
                        ready_is_b_reg <= ~ready_is_b_reg;
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    cur_valid_reg <= 1'b1;
                    start_reg <= item_reg.now;
                    if (cnt_reg[ready_is_b_reg] != '0)
                    begin
                        cur_id_reg <= IW'(pop_rd);
                        cur_idle_reg <= 1'b0;
                        res_reg.next_thread <= pop_rd;
                        head_reg[ready_is_b_reg] <=
                            (32'(head_reg[ready_is_b_reg]) + 1 >= THREAD_COUNT) ? '0
                            : head_reg[ready_is_b_reg] + 1'b1;
                        cnt_reg[ready_is_b_reg] <= cnt_reg[ready_is_b_reg] - 1'b1;
                    end
                    else
                    begin
                        cur_id_reg <= '0;
                        cur_idle_reg <= 1'b1;
                        res_reg.next_is_idle <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // queue counts never exceed depth
    a_cnt0: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg[0]) <= THREAD_COUNT) else $error("queue 0 overfilled");
    a_cnt1: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg[1]) <= THREAD_COUNT) else $error("queue 1 overfilled");
    // idle result carries thread zero
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && res_reg.next_is_idle |-> res_reg.next_thread == '0)
        else $error("idle with thread number");
    // a pop leaves the current thread valid
    a_cur: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> cur_valid_reg) else $error("current lost");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the quantum round robin scheduler core
// depends on qrrs_pkg, qrrs_in_if / qrrs_out_if and the core module
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int NTHR = 32;

    // predicts scheduler results and holds them until they arrive
    class sched_scoreboard;
        logic [4:0]  slots [2][NTHR];
        int          head [2];
        int          tail [2];
        int          count [2];
        bit          ready_b;
        logic [31:0] quantum;
        logic [31:0] qleft [NTHR];
        logic [63:0] cpu [NTHR+1];
        bit          cur_valid;
        bit          cur_idle;
        logic [4:0]  cur_id;
        logic [63:0] start;
        qrrs_pkg::out_item_t pending [$];
        int          errors;

        function new();
            for (int i = 0; i < NTHR; i++) qleft[i] = qrrs_pkg::QUANTUM_RESET;
            for (int i = 0; i <= NTHR; i++) cpu[i] = '0;
            head = '{0, 0}; tail = '{0, 0}; count = '{0, 0};
            ready_b = 0; quantum = qrrs_pkg::QUANTUM_RESET;
            cur_valid = 0; cur_idle = 0; cur_id = '0; start = '0;
            errors = 0;
        endfunction

        function bit enqueue(bit q, logic [4:0] id);
            if (count[q] >= NTHR) return 1;
            slots[q][tail[q]] = id;
            tail[q] = (tail[q] + 1) % NTHR;
            count[q]++;
            return 0;
        endfunction

        function logic [4:0] dequeue(bit q);
            logic [4:0] id;
            id = slots[q][head[q]];
            head[q] = (head[q] + 1) % NTHR;
            count[q]--;
            return id;
        endfunction

        // work out the result of one accepted transaction
        function void note_input(qrrs_pkg::in_item_t it);
            qrrs_pkg::out_item_t r;
            logic [63:0] run;
            int          idx;
            r = '0;
            case (qrrs_pkg::kind_t'(it.kind))
                qrrs_pkg::KIND_READY: r.queue_error = enqueue(ready_b, it.thread_id);
                qrrs_pkg::KIND_EXPIRED:
                begin
                    qleft[it.thread_id] = quantum;
                    r.queue_error = enqueue(!ready_b, it.thread_id);
                end
                qrrs_pkg::KIND_SCHED:
                begin
                    if (cur_valid)
                    begin
                        idx = cur_idle ? NTHR : cur_id;
                        run = it.now - start;
                        cpu[idx] = cpu[idx] + run;
                        r.outgoing_cpu_time = cpu[idx];
                        if (!cur_idle)
                        begin
                            if (it.current_state == qrrs_pkg::ST_RUNNING)
                            begin
                                if (run >= {32'd0, qleft[idx]})
                                begin
                                    qleft[idx] = quantum;
                                    r.queue_error = enqueue(!ready_b, cur_id);
                                end
                                else
                                begin
                                    qleft[idx] = qleft[idx] - run[31:0];
                                    r.queue_error = enqueue(ready_b, cur_id);
                                end
                            end
                            else if (it.current_state == qrrs_pkg::ST_WAITING)
                            begin
                                if (run >= {32'd0, qleft[idx]})
                                begin
                                    qleft[idx] = '0;
                                    r.quantum_exhausted = 1;
                                end
                                else
                                    qleft[idx] = qleft[idx] - run[31:0];
                            end
                        end
                    end
                    if (count[ready_b] == 0) ready_b = !ready_b;
                    if (count[ready_b] != 0)
                    begin
                        cur_id = dequeue(ready_b);
                        cur_idle = 0;
                        r.next_thread = cur_id;
                    end
                    else
                    begin
                        cur_id = '0;
                        cur_idle = 1;
                        r.next_is_idle = 1;
                    end
                    cur_valid = 1;
                    start = it.now;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(qrrs_pkg::out_item_t got);
            qrrs_pkg::out_item_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.next_thread !== e.next_thread)
            begin
                $error("next_thread exp %0d got %0d", e.next_thread, got.next_thread);
                errors++;
            end
            if (got.next_is_idle !== e.next_is_idle)
            begin
                $error("next_is_idle exp %0d got %0d", e.next_is_idle, got.next_is_idle);
                errors++;
            end
            if (got.outgoing_cpu_time !== e.outgoing_cpu_time)
            begin
                $error("outgoing_cpu_time exp %0h got %0h",
                       e.outgoing_cpu_time, got.outgoing_cpu_time);
                errors++;
            end
            if (got.quantum_exhausted !== e.quantum_exhausted)
            begin
                $error("quantum_exhausted exp %0d got %0d",
                       e.quantum_exhausted, got.quantum_exhausted);
                errors++;
            end
            if (got.queue_error !== e.queue_error)
            begin
                $error("queue_error exp %0d got %0d", e.queue_error, got.queue_error);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = '0;
    logic [63:0] sys_now = '0;
    int          rx_cycle = 0;
    int          rx_mode = 0;

    qrrs_in_if  in_ch ();
    qrrs_out_if out_ch ();

    sched_scoreboard sb = new();

    quantum_round_robin_scheduler_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    // receiver stall pattern, with its mode drawn at random from four
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 200 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: out_ch.ready <= 1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= (rx_cycle % 7 < 2);
            default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // result sampling
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

    // offer one transaction and hold it until accepted
    task automatic send_item(qrrs_pkg::in_item_t it);
        @(negedge clk);
        in_ch.valid = 1;
        in_ch.data = it;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(it);
    endtask

    task automatic idle_gap(int n);
        @(negedge clk);
        in_ch.valid = 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_kind(qrrs_pkg::kind_t k, logic [4:0] tid, logic [63:0] t,
                             logic [1:0] st);
        qrrs_pkg::in_item_t it;
        it.kind = k;
        it.thread_id = tid;
        it.now = t;
        it.current_state = st;
        send_item(it);
    endtask

    // wait for all results, then write the quantum register
    task automatic drain_and_configure(logic [31:0] q);
        idle_gap(1);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_we = 1;
        cfg_wdata = q;
        @(negedge clk);
        cfg_we = 0;
        sb.quantum = q;
    endtask

    // random phase: mostly plausible scheduling traffic, some noise
    task automatic random_phase(int n);
        qrrs_pkg::in_item_t it;
        int       burst;
        logic [63:0] delta;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
        begin
            it.kind = ($urandom_range(0, 9) < 5) ? qrrs_pkg::KIND_SCHED :
                      ($urandom_range(0, 2) == 0) ? qrrs_pkg::KIND_EXPIRED
                      : qrrs_pkg::KIND_READY;
            if ($urandom_range(0, 49) == 0) it.kind = qrrs_pkg::KIND_NONE;
            it.thread_id = $urandom_range(0, NTHR - 1);
            it.current_state = ($urandom_range(0, 3) != 0) ?
                               (($urandom_range(0, 1)) ? qrrs_pkg::ST_RUNNING
                               : qrrs_pkg::ST_WAITING) : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: delta = {$urandom, $urandom};
                1, 2: delta = $urandom_range(0, 2 * 60000);
                default: delta = $urandom_range(0, 40);
            endcase
            sys_now = sys_now + delta;
            it.now = ($urandom_range(0, 99) == 0) ? {$urandom, $urandom} : sys_now;
            send_item(it);
            if (--burst == 0)
            begin
                idle_gap($urandom_range(0, 6));
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // directed: schedule with no current thread, extremes of thread ids
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd100, qrrs_pkg::ST_RUNNING);
        send_kind(qrrs_pkg::KIND_READY, 5'd0, '0, qrrs_pkg::ST_RUNNING);
        send_kind(qrrs_pkg::KIND_READY, 5'd31, '1, qrrs_pkg::ST_ZOMBIE);
        send_kind(qrrs_pkg::KIND_EXPIRED, 5'd31, '0, qrrs_pkg::ST_RUNNING);
        // idle outgoing
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd200, qrrs_pkg::ST_RUNNING);
        // running, quantum left
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd300, qrrs_pkg::ST_RUNNING);
        // running, quantum used
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd200000, qrrs_pkg::ST_RUNNING);
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd200010, qrrs_pkg::ST_WAITING);
        // quantum zeroed
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd900000, qrrs_pkg::ST_WAITING);
        // time goes backwards
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd5, qrrs_pkg::ST_READY);
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, '1, qrrs_pkg::ST_ZOMBIE);
        send_kind(qrrs_pkg::KIND_NONE, 5'd17, '1, qrrs_pkg::ST_ZOMBIE);
        send_kind(qrrs_pkg::KIND_READY, 5'd7, '0, qrrs_pkg::ST_RUNNING);
        // duplicate add
        send_kind(qrrs_pkg::KIND_READY, 5'd7, '0, qrrs_pkg::ST_RUNNING);
        send_kind(qrrs_pkg::KIND_SCHED, 5'd0, 64'd10, qrrs_pkg::ST_RUNNING);
        // overflow both queues
        for (int i = 0; i < NTHR + 1; i++)
            send_kind(qrrs_pkg::KIND_READY, i[4:0], '0, qrrs_pkg::ST_RUNNING);
        for (int i = 0; i < NTHR + 1; i++)
            send_kind(qrrs_pkg::KIND_EXPIRED, i[4:0], '0, qrrs_pkg::ST_RUNNING);
        sys_now = 64'd1000;

        random_phase(235);
        drain_and_configure(32'd1);
        random_phase(235);
        drain_and_configure(32'hFFFF_FFFF);
        random_phase(235);
        drain_and_configure($urandom_range(1, 100));
        random_phase(235);
        drain_and_configure($urandom);
        random_phase(235);

        idle_gap(1);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // overall time limit
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
